FILE: hdl/utf8_to_codepoint_decoder_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODEPOINT_DECODER_DEFINES_SVH
`define UTF8_TO_CODEPOINT_DECODER_DEFINES_SVH

// Same-cycle implication
`define UTF8DEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define UTF8DEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/utf8dec_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Item types, decoder state, status codes, code point limits, lead byte constants and a scalar value check.
// ----------------------------------------------------------------------------
package utf8dec_pkg;

   localparam int CP_WIDTH = 21;

   localparam logic [CP_WIDTH-1:0] REPL_RESET   = 21'd63;
   localparam logic [CP_WIDTH-1:0] SURR_FIRST   = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] SURR_LAST    = 21'h00DFFF;
   localparam logic [CP_WIDTH-1:0] CP_MAX       = 21'h10FFFF;

   // Lead byte patterns: (byte & mask) == code
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   typedef enum logic [1:0] {
      STATUS_VALID     = 2'd0,
      STATUS_BAD_LEAD  = 2'd1,
      STATUS_BAD_VALUE = 2'd2,
      STATUS_TRUNCATED = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_item_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      status_type          status;
      logic [1:0]          unconsumed_bytes;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]          bytes_expected;
      logic [1:0]          bytes_held;
      logic [CP_WIDTH-1:0] partial_value;
   } dec_state_type;

   // Scalar value: not a surrogate and not above the last code point
   function automatic logic cp_is_valid(input logic [CP_WIDTH-1:0] cp);
      return (cp < SURR_FIRST) || ((cp > SURR_LAST) && (cp <= CP_MAX));
   endfunction

endpackage

FILE: hdl/utf8dec_step.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder byte step
// Combinational update of the sequence state for one byte, plus the
// result item that the byte causes, if any.
// ----------------------------------------------------------------------------
module utf8dec_step
   import utf8dec_pkg::*;
(
   input  dec_state_type        cur_state,
   input  req_item_type         item,
   input  logic [CP_WIDTH-1:0]  replacement_char,
   output dec_state_type        nxt_state,
   output logic                 res_valid,
   output rsp_item_type         res_item
);

   logic [7:0]          byte_v;
   logic [CP_WIDTH-1:0] shifted;

   assign byte_v  = item.in_byte;
   // Continuation: shift in the low six bits, high bits ignored
   assign shifted = {cur_state.partial_value[CP_WIDTH-7:0], byte_v[5:0]};

   always_comb begin
      nxt_state = cur_state;
      res_valid = 1'b0;
      res_item  = '{code_point: '0, status: STATUS_VALID, unconsumed_bytes: 2'd0};

      if (cur_state.bytes_expected == 2'd0) begin
         // Awaiting a lead byte
         if (!byte_v[7]) begin
            res_valid           = 1'b1;
            res_item.code_point = {{(CP_WIDTH-8){1'b0}}, byte_v};
         end else if ((byte_v & LEAD2_MASK) == LEAD2_CODE) begin
            nxt_state.partial_value  = {{(CP_WIDTH-5){1'b0}}, byte_v[4:0]};
            nxt_state.bytes_expected = 2'd1;
            nxt_state.bytes_held     = 2'd1;
         end else if ((byte_v & LEAD3_MASK) == LEAD3_CODE) begin
            nxt_state.partial_value  = {{(CP_WIDTH-4){1'b0}}, byte_v[3:0]};
            nxt_state.bytes_expected = 2'd2;
            nxt_state.bytes_held     = 2'd1;
         end else if ((byte_v & LEAD4_MASK) == LEAD4_CODE) begin
            nxt_state.partial_value  = {{(CP_WIDTH-3){1'b0}}, byte_v[2:0]};
            nxt_state.bytes_expected = 2'd3;
            nxt_state.bytes_held     = 2'd1;
         end else begin
            res_valid           = 1'b1;
            res_item.code_point = replacement_char;
            res_item.status     = STATUS_BAD_LEAD;
         end
      end else begin
         // Inside a sequence
         nxt_state.partial_value  = shifted;
         nxt_state.bytes_expected = cur_state.bytes_expected - 2'd1;
         nxt_state.bytes_held     = cur_state.bytes_held + 2'd1;
         if (cur_state.bytes_expected == 2'd1) begin
            res_valid = 1'b1;
            if (cp_is_valid(shifted)) begin
               res_item.code_point = shifted;
            end else begin
               res_item.code_point = replacement_char;
               res_item.status     = STATUS_BAD_VALUE;
            end
            nxt_state.bytes_held    = 2'd0;
            nxt_state.partial_value = '0;
         end
      end

      // Stream ends with a sequence still open
      if (item.end_of_input && (nxt_state.bytes_expected != 2'd0)) begin
         res_valid                 = 1'b1;
         res_item.code_point       = '0;
         res_item.status           = STATUS_TRUNCATED;
         res_item.unconsumed_bytes = nxt_state.bytes_held;
         nxt_state                 = '0;
      end
   end

endmodule

FILE: hdl/utf8_to_codepoint_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to code point decoder
// Takes one byte per item and returns a code point item when a sequence of
// one to four bytes completes. Invalid leads, surrogates and values above
// 0x10FFFF give the programmable replacement character; a sequence left open
// at end of input gives a truncated item carrying its byte count. Bytes are
// taken one per cycle: an item passes through an input register, the byte
// step logic and a result register, so a byte is accepted every cycle while
// the result side keeps up. Continuation bytes are not checked for their
// 10xxxxxx pattern. The replacement register resets to '?' and is written
// through the csr channel; the user must write it only while the decoder is
// idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "utf8_to_codepoint_decoder_defines.svh"

module utf8_to_codepoint_decoder
   import utf8dec_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  req_item_type        req_item,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_item_type        rsp_item,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CP_WIDTH-1:0] csr_data
);

   logic                in_vld_ff, in_vld_in;
   req_item_type        in_item_ff;
   dec_state_type       state_ff, state_in;
   logic                out_vld_ff, out_vld_in;
   rsp_item_type        out_item_ff;
   logic [CP_WIDTH-1:0] repl_ff;

   logic                step_res_vld;
   rsp_item_type        step_res;
   logic                fire;

   // Byte step logic
   utf8dec_step u_step (
      .cur_state        (state_ff),
      .item             (in_item_ff),
      .replacement_char (repl_ff),
      .nxt_state        (state_in),
      .res_valid        (step_res_vld),
      .res_item         (step_res)
   );

   // The held item moves on when its result, if any, has room
   assign fire      = in_vld_ff && (!step_res_vld || !out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;
   assign in_vld_in = req_valid || (in_vld_ff && !fire);
   assign out_vld_in = (fire && step_res_vld) || (out_vld_ff && !rsp_ready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   // Sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && step_res_vld) begin
         out_item_ff <= step_res;
      end
   end

   // Replacement character register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPL_RESET;
      end else if (csr_valid && csr_ready) begin
         repl_ff <= csr_data;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_item_ff;

   // Checks
   `UTF8DEC_ASSERT_NOW(a_idle_clean, clock, reset, state_ff.bytes_expected == 2'd0,
      (state_ff.bytes_held == 2'd0) && (state_ff.partial_value == '0),
      "idle decoder holds sequence bytes")
   `UTF8DEC_ASSERT_NOW(a_open_held, clock, reset, state_ff.bytes_expected != 2'd0,
      state_ff.bytes_held != 2'd0, "open sequence with no bytes held")
   `UTF8DEC_ASSERT_NEXT(a_end_idle, clock, reset, fire && in_item_ff.end_of_input,
      state_ff.bytes_expected == 2'd0, "sequence left open after end of input")
   `UTF8DEC_ASSERT_NOW(a_unconsumed, clock, reset, out_vld_ff,
      (out_item_ff.status == STATUS_TRUNCATED) == (out_item_ff.unconsumed_bytes != 2'd0),
      "byte count does not match truncated status")

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder testbench
// Feeds byte streams through the decoder and checks every code point item
// against a byte-level decode kept in the bench. A short directed run covers
// each sequence length, the replacement cases and end-of-input handling with
// the replacement register at its reset value. Random phases follow, one per
// replacement setting, with the extremes among them. The sender works in
// bursts and the receiver stalls in shifting patterns.
// ----------------------------------------------------------------------------
module testbench;
   import utf8dec_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 220;
   localparam int MAX_REPORTS    = 20;
   localparam logic [CP_WIDTH-1:0] DEFAULT_REPL = 21'd63;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_item_type        req_item  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_item_type        rsp_item;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CP_WIDTH-1:0] csr_data  = '0;

   // Decode state and replacement value as the bench tracks them
   dec_state_type       dec_state  = '0;
   logic [CP_WIDTH-1:0] repl_char  = DEFAULT_REPL;
   rsp_item_type        pending_cps[$];

   int unsigned error_count = 0;
   int unsigned bytes_sent  = 0;
   int unsigned cps_checked = 0;
   int unsigned repl_writes = 0;
   int unsigned burst_left  = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_left  = 0;
   int unsigned status_seen[4] = '{0, 0, 0, 0};
   logic [31:0] rsp_cycle   = '0;

   utf8_to_codepoint_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Unicode scalar value: no surrogate, nothing above the last plane
   function automatic bit is_scalar_value(input logic [CP_WIDTH-1:0] cp);
      return (cp <= 21'h00D7FF) || (cp >= 21'h00E000 && cp <= 21'h10FFFF);
   endfunction

   // Advance the decode by one byte; returns 1 when the byte yields an item
   function automatic bit decode_byte(input req_item_type item,
                                      output rsp_item_type cp_out);
      logic [7:0] b;
      bit         produced;
      b        = item.in_byte;
      produced = 1'b0;
      cp_out   = '0;
      if (dec_state.bytes_expected == 2'd0) begin
         casez (b)
            8'b0???????: begin
               cp_out.code_point = {13'd0, b};
               cp_out.status     = STATUS_VALID;
               produced          = 1'b1;
            end
            8'b110?????: dec_state = '{2'd1, 2'd1, {16'd0, b[4:0]}};
            8'b1110????: dec_state = '{2'd2, 2'd1, {17'd0, b[3:0]}};
            8'b11110???: dec_state = '{2'd3, 2'd1, {18'd0, b[2:0]}};
            default: begin
               // stray continuation or 11111xxx where a lead belongs
               cp_out.code_point = repl_char;
               cp_out.status     = STATUS_BAD_LEAD;
               produced          = 1'b1;
            end
         endcase
      end else begin
         // any byte inside a sequence counts as a continuation
         dec_state.partial_value  = {dec_state.partial_value[14:0], b[5:0]};
         dec_state.bytes_expected = dec_state.bytes_expected - 2'd1;
         dec_state.bytes_held     = dec_state.bytes_held + 2'd1;
         if (dec_state.bytes_expected == 2'd0) begin
            if (is_scalar_value(dec_state.partial_value)) begin
               cp_out.code_point = dec_state.partial_value;
               cp_out.status     = STATUS_VALID;
            end else begin
               cp_out.code_point = repl_char;
               cp_out.status     = STATUS_BAD_VALUE;
            end
            produced  = 1'b1;
            dec_state = '0;
         end
      end
      // stream ends inside a sequence
      if (item.end_of_input && dec_state.bytes_expected != 2'd0) begin
         cp_out.code_point       = '0;
         cp_out.status           = STATUS_TRUNCATED;
         cp_out.unconsumed_bytes = dec_state.bytes_held;
         produced                = 1'b1;
         dec_state               = '0;
      end
      return produced;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t mismatch: %s", $time, what);
      end
   endtask

   // Send one byte item, with a random gap when a burst runs out
   task automatic send_byte(input logic [7:0] b, input bit last);
      rsp_item_type cp_exp;
      int unsigned  gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_item  <= '{in_byte: b, end_of_input: last};
      do @(posedge clock); while (req_ready !== 1'b1);
      bytes_sent++;
      if (decode_byte(req_item, cp_exp)) begin
         pending_cps.push_back(cp_exp);
      end
   endtask

   // Hold the sender until every expected item is back, then let the pipe settle
   task automatic drain_decoder();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_cps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_replacement(input logic [CP_WIDTH-1:0] value);
      drain_decoder();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      repl_char = value;
      repl_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random character: mostly well formed, some noise and cut-short forms
   task automatic send_random_char();
      int unsigned kind;
      int unsigned len;
      int unsigned keep;
      logic [7:0]  lead;
      logic [7:0]  cont;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         send_byte(8'($urandom), $urandom_range(0, 24) == 0);
      end else begin
         if (kind < 30)      len = 1;
         else if (kind < 50) len = 2;
         else if (kind < 75) len = 3;
         else                len = 4;
         case (len)
            1: lead = {1'b0, 7'($urandom)};
            2: lead = {3'b110, 5'($urandom)};
            3: lead = ($urandom_range(0, 5) == 0) ? 8'hED : {4'b1110, 4'($urandom)};
            default: begin
               // mostly F0..F4, sometimes F5..F7 which lands above range if the sequence completes
               lead = {5'b11110, ($urandom_range(0, 3) == 0) ? 3'($urandom)
                                                             : 3'($urandom_range(0, 4))};
            end
         endcase
         keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len - 1;
         send_byte(lead, $urandom_range(0, 29) == 0);
         repeat (keep) begin
            cont = ($urandom_range(0, 7) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
            send_byte(cont, $urandom_range(0, 29) == 0);
         end
      end
   endtask

   // Every sequence length: both one-byte bounds, the two- and four-byte maxima and a three-byte character
   task automatic test_lengths();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF4, 1'b0);
      send_byte(8'h8F, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
   endtask

   // Surrogate, above range, two bad leads, unchecked continuation high bits
   task automatic test_invalid_input();
      send_byte(8'hED, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hF4, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h29, 1'b1);
   endtask

   // Stream ends mid-sequence, then ends on a lone byte
   task automatic test_end_of_input();
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
      send_byte(8'h41, 1'b1);
   endtask

   task automatic test_random_streams(input logic [CP_WIDTH-1:0] repl_value,
                                      input int unsigned n_items);
      int unsigned first;
      write_replacement(repl_value);
      first = bytes_sent;
      while (bytes_sent - first < n_items) begin
         send_random_char();
         if ($urandom_range(0, 199) == 0) begin
            drain_decoder();
         end
      end
      // close the stream so the next phase starts from idle
      send_byte(8'h0A, 1'b1);
   endtask

   // Receiver: ready pattern chosen by bits 9:8 of a free-running counter
   always @(negedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      case (rsp_cycle[9:8])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 9) < 7);
         2'd2: rsp_ready <= (rsp_cycle[1:0] == 2'd0);
         default: begin
            if (stall_left != 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(4, 16);
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // Check each accepted code point item against the oldest expectation
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_cps.size() == 0) begin
            report_mismatch($sformatf("item with none expected: cp %h status %0d",
                                      rsp_item.code_point, rsp_item.status));
         end else begin
            want = pending_cps.pop_front();
            cps_checked++;
            status_seen[want.status]++;
            if (rsp_item.code_point !== want.code_point) begin
               report_mismatch($sformatf("code_point %h, want %h",
                                         rsp_item.code_point, want.code_point));
            end
            if (rsp_item.status !== want.status) begin
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_item.status, want.status));
            end
            if (rsp_item.unconsumed_bytes !== want.unconsumed_bytes) begin
               report_mismatch($sformatf("unconsumed_bytes %0d, want %0d",
                                         rsp_item.unconsumed_bytes, want.unconsumed_bytes));
            end
         end
      end
   end

   // Watchdog: too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d items outstanding",
                  idle_cycles, pending_cps.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_lengths();
      test_invalid_input();
      test_end_of_input();
      test_random_streams(21'h000000, PHASE_ITEMS);
      test_random_streams(21'h10FFFF, PHASE_ITEMS);
      test_random_streams(21'h1FFFFF, PHASE_ITEMS);
      test_random_streams(21'h00D800, PHASE_ITEMS);
      test_random_streams(21'($urandom), PHASE_ITEMS);
      drain_decoder();

      $display("sent %0d bytes over %0d replacement settings; checked %0d items",
               bytes_sent, repl_writes + 1, cps_checked);
      $display("valid %0d, bad lead %0d, bad value %0d, truncated %0d, mismatches %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
